/* rtl/sapd_pkg.sv */
package sapd_pkg;

  localparam int BINS  = 1024;
  localparam int BIN_W = $clog2(BINS);

  // reciprocal of the second average divisor: floor(2^RECIP_SHIFT / d) + 1
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HANG    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GROWTH  = 2'd3;

  localparam logic [7:0]  DIVISOR_RESET = 8'd4;
  localparam logic [15:0] STEP_RESET    = 16'd256;
  localparam logic [15:0] MULT_ONE      = 16'd256;
  localparam logic [15:0] MULT_MAX      = 16'hffff;
  localparam logic [15:0] LEVEL_MIN     = 16'h8000;

  typedef struct packed {
    logic [15:0] fa;
    logic [15:0] sa;
    logic [15:0] hl;
    logic [15:0] mu;
  } st_t;

  typedef struct packed {
    logic               busy;
    logic [RECIP_W-1:0] value;
  } recip_t;

endpackage

/* rtl/spectrum_average_peak_decay.sv */
// Per-bin spectrum averaging with peak hang and accelerating decay.
// Input channel: one bin level per item (in_bin_index, in_bin_level), taken
// when in_valid is high and in_stall low. Result channel: display and
// waterfall level of that bin, delivered when out_valid is high and out_stall
// low, in the order the items came in.
// Items for distinct bins flow at one per cycle while the receiver does not
// stall, through the register stages (state read, first average, difference,
// two multipliers, update and write-back). An item for a bin that is still
// in flight waits until the earlier one has been written back.
// After reset the per-bin state memory is cleared, one bin a cycle, for all
// 1024 bins, and the reciprocal of the divisor is formed; in_stall is high
// meanwhile. A write of second_avg_divisor starts that reciprocal run again,
// with in_stall high. The user must write configuration through cfg_wr_en,
// cfg_index and cfg_wr_data only while no item is in flight; the block itself
// does not enforce this.
// When the receiver stalls, the result waits in the output register and the
// stages behind it keep filling; in_stall rises once all stages are full.
module spectrum_average_peak_decay
  import sapd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [9:0]           in_bin_index,
  input  logic signed [15:0]   in_bin_level,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   out_display_level,
  output logic signed [15:0]   out_waterfall_level,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wr_data
);

  // configuration
  logic [7:0]  divisor_r;
  logic        hang_r;
  logic [15:0] step_r;
  logic [15:0] growth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divisor_r <= DIVISOR_RESET;
      hang_r    <= 1'b1;
      step_r    <= STEP_RESET;
      growth_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_DIVISOR: divisor_r <= cfg_wr_data[7:0];
        CFG_HANG:    hang_r    <= cfg_wr_data[0];
        CFG_STEP:    step_r    <= cfg_wr_data;
        CFG_GROWTH:  growth_r  <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  recip_t recip;

  sapd_recip u_recip (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cfg_wr_en && (cfg_index == CFG_DIVISOR)),
    .divisor (divisor_r),
    .recip   (recip)
  );

  // clearing pass
  logic [BIN_W:0] clr_cnt_r;
  logic           clr_busy;

  assign clr_busy = !clr_cnt_r[BIN_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (clr_busy) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // pipeline registers
  logic              a_v_r, b_v_r, c_v_r, d_v_r, e_v_r, out_v_r;
  logic [BIN_W-1:0]  a_idx_r, b_idx_r, c_idx_r, d_idx_r, e_idx_r;
  logic [15:0]       a_x_r;
  st_t               rd_r;
  logic [15:0]       b_fa_r, b_sa_r, b_hl_r, b_mu_r;
  logic [15:0]       c_fa_r, c_sa_r, c_hl_r, c_mu_r, c_mag_r;
  logic              c_neg_r;
  logic [15:0]       d_fa_r, d_sa_r, d_hl_r, d_mu_r;
  logic              d_neg_r;
  logic [40:0]       d_prod_r;
  logic [31:0]       d_fallp_r;
  logic [15:0]       e_fa_r, e_sa_r, e_hl_r, e_mu_r, e_hl_dec_r, e_mu_grown_r;
  logic [15:0]       out_disp_r, out_wf_r;

  // stage loads, each stage takes its upstream item when it is empty or moving on
  logic ld_out, ld_e, ld_d, ld_c, ld_b, ld_a;
  logic hazard;
  logic in_acc;

  assign ld_out = !out_v_r || !out_stall;
  assign ld_e   = !e_v_r || ld_out;
  assign ld_d   = !d_v_r || ld_e;
  assign ld_c   = !c_v_r || ld_d;
  assign ld_b   = !b_v_r || ld_c;
  assign ld_a   = !a_v_r || ld_b;

  // one item per bin in flight, so every read sees the last write-back
  assign hazard = (a_v_r && (a_idx_r == in_bin_index)) ||
                  (b_v_r && (b_idx_r == in_bin_index)) ||
                  (c_v_r && (c_idx_r == in_bin_index)) ||
                  (d_v_r && (d_idx_r == in_bin_index)) ||
                  (e_v_r && (e_idx_r == in_bin_index));

  assign in_stall = clr_busy || recip.busy || !ld_a || hazard;
  assign in_acc   = in_valid && !in_stall;

  // stage a: first average
  logic [16:0] diff1, half1, fa_sum;
  logic [15:0] fa_nxt;

  assign diff1  = {a_x_r[15], a_x_r} - {rd_r.fa[15], rd_r.fa};
  // halve toward zero
  assign half1  = 17'($signed(diff1 + {16'd0, diff1[16]}) >>> 1);
  assign fa_sum = {rd_r.fa[15], rd_r.fa} + half1;
  assign fa_nxt = fa_sum[15:0];

  // stage b: difference for the second average
  logic [16:0] diff2, mag2;

  assign diff2 = {b_fa_r[15], b_fa_r} - {b_sa_r[15], b_sa_r};
  assign mag2  = diff2[16] ? (17'd0 - diff2) : diff2;

  // stage c: quotient by reciprocal, and decay fall
  logic [40:0] prod_nxt;
  logic [31:0] fallp_nxt;

  assign prod_nxt  = 41'(c_mag_r) * 41'(recip.value);
  assign fallp_nxt = 32'(step_r) * 32'(c_mu_r);

  // stage d: apply quotient, decay and multiplier growth
  logic [15:0] q;
  logic [16:0] sa_sum;
  logic [23:0] fall;
  logic [25:0] hl_v;
  logic [15:0] hl_dec_nxt;
  logic [16:0] mu_sum;
  logic [15:0] mu_grown_nxt;

  assign q      = d_prod_r[RECIP_SHIFT+15:RECIP_SHIFT];
  assign sa_sum = {d_sa_r[15], d_sa_r} + (d_neg_r ? (17'd0 - {1'b0, q}) : {1'b0, q});
  assign fall   = d_fallp_r[31:8];
  assign hl_v   = {{10{d_hl_r[15]}}, d_hl_r} - {2'b00, fall};
  assign hl_dec_nxt = ($signed(hl_v) < -26'sd32768) ? LEVEL_MIN : hl_v[15:0];
  assign mu_sum = {1'b0, d_mu_r} + {1'b0, growth_r};
  assign mu_grown_nxt = mu_sum[16] ? MULT_MAX : mu_sum[15:0];

  // stage e: hang decision and write-back
  logic [15:0] hl_new, mu_new;

  always_comb begin
    if (!hang_r) begin
      hl_new = e_sa_r;
      mu_new = e_mu_r;
    end else if ($signed(e_hl_r) < $signed(e_sa_r)) begin
      hl_new = e_sa_r;
      mu_new = MULT_ONE;
    end else begin
      hl_new = e_hl_dec_r;
      mu_new = e_mu_grown_r;
    end
  end

  // state memory
  st_t              st_mem [BINS];
  logic             mem_we;
  logic [BIN_W-1:0] mem_wa;
  st_t              mem_wd;

  always_comb begin
    if (clr_busy) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r[BIN_W-1:0];
      mem_wd = '{fa: 16'd0, sa: 16'd0, hl: 16'd0, mu: MULT_ONE};
    end else begin
      mem_we = e_v_r && ld_out;
      mem_wa = e_idx_r;
      mem_wd = '{fa: e_fa_r, sa: e_sa_r, hl: hl_new, mu: mu_new};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      st_mem[mem_wa] <= mem_wd;
    end
    if (in_acc) begin
      rd_r <= st_mem[in_bin_index];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      c_v_r   <= 1'b0;
      d_v_r   <= 1'b0;
      e_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (ld_a)   a_v_r   <= in_acc;
      if (ld_b)   b_v_r   <= a_v_r;
      if (ld_c)   c_v_r   <= b_v_r;
      if (ld_d)   d_v_r   <= c_v_r;
      if (ld_e)   e_v_r   <= d_v_r;
      if (ld_out) out_v_r <= e_v_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_idx_r <= in_bin_index;
      a_x_r   <= in_bin_level;
    end
    if (ld_b) begin
      b_idx_r <= a_idx_r;
      b_fa_r  <= fa_nxt;
      b_sa_r  <= rd_r.sa;
      b_hl_r  <= rd_r.hl;
      b_mu_r  <= rd_r.mu;
    end
    if (ld_c) begin
      c_idx_r <= b_idx_r;
      c_fa_r  <= b_fa_r;
      c_sa_r  <= b_sa_r;
      c_hl_r  <= b_hl_r;
      c_mu_r  <= b_mu_r;
      c_neg_r <= diff2[16];
      c_mag_r <= mag2[15:0];
    end
    if (ld_d) begin
      d_idx_r   <= c_idx_r;
      d_fa_r    <= c_fa_r;
      d_sa_r    <= c_sa_r;
      d_hl_r    <= c_hl_r;
      d_mu_r    <= c_mu_r;
      d_neg_r   <= c_neg_r;
      d_prod_r  <= prod_nxt;
      d_fallp_r <= fallp_nxt;
    end
    if (ld_e) begin
      e_idx_r      <= d_idx_r;
      e_fa_r       <= d_fa_r;
      e_sa_r       <= sa_sum[15:0];
      e_hl_r       <= d_hl_r;
      e_mu_r       <= d_mu_r;
      e_hl_dec_r   <= hl_dec_nxt;
      e_mu_grown_r <= mu_grown_nxt;
    end
    if (ld_out) begin
      out_disp_r <= hl_new;
      out_wf_r   <= e_fa_r;
    end
  end

  assign out_valid           = out_v_r;
  assign out_display_level   = out_disp_r;
  assign out_waterfall_level = out_wf_r;

  // no two items of one bin in stages a and b, or in stages a and e, at once
  assert property (@(posedge clk) disable iff (!rst_n)
    (a_v_r && b_v_r) |-> (a_idx_r != b_idx_r))
    else $error("same bin in stages a and b");

  assert property (@(posedge clk) disable iff (!rst_n)
    (a_v_r && e_v_r) |-> (a_idx_r != e_idx_r))
    else $error("same bin in stages a and e");

  // the clearing pass never overlaps items in flight
  assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !(a_v_r || b_v_r || c_v_r || d_v_r || e_v_r))
    else $error("item in flight during clearing pass");

  // an accepted item enters stage a
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> a_v_r)
    else $error("accepted item lost");

endmodule

/* rtl/sapd_recip.sv */
module sapd_recip
  import sapd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [7:0] divisor,
  output recip_t     recip
);

  localparam int CNT_W = $clog2(RECIP_SHIFT + 1);

  logic               busy_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [8:0]         rem_r;
  logic [RECIP_W-1:0] quo_r;
  logic [RECIP_W-1:0] val_r;

  logic [8:0]         d_eff;
  logic [8:0]         trial;
  logic               qbit;
  logic [8:0]         rem_nxt;
  logic [RECIP_W-1:0] quo_nxt;

  // a divisor of zero acts as one
  assign d_eff   = (divisor == 8'd0) ? 9'd1 : {1'b0, divisor};
  // dividend is a single one at bit RECIP_SHIFT, zeros below
  assign trial   = {rem_r[7:0], (cnt_r == CNT_W'(RECIP_SHIFT))};
  assign qbit    = (trial >= d_eff);
  assign rem_nxt = qbit ? (trial - d_eff) : trial;
  assign quo_nxt = {quo_r[RECIP_W-2:0], qbit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(RECIP_SHIFT);
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(RECIP_SHIFT);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      if (cnt_r == '0) begin
        val_r <= quo_nxt + 1'b1;
      end
    end
  end

  assign recip.busy  = busy_r;
  assign recip.value = val_r;

endmodule
